[sv/nnrs_pkg.sv]
// Shared constants, types and address helpers for the nearest-neighbor RGB resize unit.
package nnrs_pkg;

  localparam int unsigned MAX_WIDTH  = 256;
  localparam int unsigned MAX_HEIGHT = 256;

  localparam int unsigned POS_W   = 8;
  localparam int unsigned SIZE_W  = 9;
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned PIXEL_W = 3 * CHAN_W;
  localparam int unsigned CFG_IDX_W = 8;

  localparam int unsigned DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  localparam int unsigned DIVIDEND_W = POS_W + SIZE_W;
  localparam int unsigned QUOT_W     = SIZE_W;
  localparam int unsigned CNT_W      = $clog2(QUOT_W + 1);

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = CFG_IDX_W'(3);

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_RD,
    ST_RSP
  } nnrs_state_e;

  typedef logic [PIXEL_W-1:0] pixel_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input int unsigned max_v);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (32'(v) > max_v) begin
      r = SIZE_W'(max_v);
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] pix_addr(input logic [SIZE_W-1:0] row,
                                                 input logic [SIZE_W-1:0] col);
    return ADDR_W'(row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col);
  endfunction

endpackage

[sv/nnrs_div.sv]
// Iterative restoring divider that produces one quotient bit per cycle.
module nnrs_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [nnrs_pkg::DIVIDEND_W-1:0]  dividend_i,
  input  logic [nnrs_pkg::SIZE_W-1:0]      divisor_i,
  output logic                             busy_o,
  output logic [nnrs_pkg::QUOT_W-1:0]      quot_o
);
  import nnrs_pkg::*;

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [SIZE_W-1:0] rem_q, rem_d;
  logic [QUOT_W-1:0] low_q, low_d;
  logic [QUOT_W-1:0] quot_q, quot_d;
  logic [SIZE_W-1:0] dsor_q, dsor_d;
  logic [SIZE_W:0]   trial;

  assign trial = {rem_q, low_q[QUOT_W-1]};

  always_comb begin
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    low_d  = low_q;
    quot_d = quot_q;
    dsor_d = dsor_q;
    if (start_i) begin
      cnt_d  = CNT_W'(QUOT_W);
      rem_d  = SIZE_W'(dividend_i[DIVIDEND_W-1:QUOT_W]);
      low_d  = dividend_i[QUOT_W-1:0];
      quot_d = '0;
      dsor_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - CNT_W'(1);
      low_d = {low_q[QUOT_W-2:0], 1'b0};
      if (trial >= {1'b0, dsor_q}) begin
        rem_d  = SIZE_W'(trial - {1'b0, dsor_q});
        quot_d = {quot_q[QUOT_W-2:0], 1'b1};
      end else begin
        rem_d  = trial[SIZE_W-1:0];
        quot_d = {quot_q[QUOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    low_q  <= low_d;
    quot_q <= quot_d;
    dsor_q <= dsor_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = quot_q;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_o)
    else $error("divider not busy after start");
  a_count_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_o && !start_i) |=> (cnt_q == $past(cnt_q) - CNT_W'(1)))
    else $error("divider count did not step");
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= QUOT_W)
    else $error("divider count out of range");

endmodule

[sv/nnrs_frame_mem.sv]
// Source frame memory with one write port and one registered read port.
module nnrs_frame_mem (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [nnrs_pkg::ADDR_W-1:0] waddr_i,
  input  nnrs_pkg::pixel_t            wdata_i,
  input  logic                        re_i,
  input  logic [nnrs_pkg::ADDR_W-1:0] raddr_i,
  output nnrs_pkg::pixel_t            rdata_o
);
  import nnrs_pkg::*;

  pixel_t mem [DEPTH];
  pixel_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/nearest_neighbor_rgb_resize_unit.sv]
// Top level of the nearest-neighbor RGB resize unit: control, size registers and output word.
// A store word inside the source size is written to the frame memory in the cycle it is accepted; it gives no result.
// A read word gives its result word after these steps, in order: form the products from the
// registered position, nine divider steps, see them done, one memory read, one output load.
// One word is in flight at a time: new words stall until a read has loaded its result word.
// Reset clears control state and sets all sizes to 256; frame memory contents are not cleared.
module nearest_neighbor_rgb_resize_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [nnrs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [nnrs_pkg::SIZE_W-1:0]    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           operation_i,
  input  logic [nnrs_pkg::POS_W-1:0]     pos_x_i,
  input  logic [nnrs_pkg::POS_W-1:0]     pos_y_i,
  input  logic [nnrs_pkg::CHAN_W-1:0]    red_in_i,
  input  logic [nnrs_pkg::CHAN_W-1:0]    green_in_i,
  input  logic [nnrs_pkg::CHAN_W-1:0]    blue_in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [nnrs_pkg::CHAN_W-1:0]    red_out_o,
  output logic [nnrs_pkg::CHAN_W-1:0]    green_out_o,
  output logic [nnrs_pkg::CHAN_W-1:0]    blue_out_o,
  output logic                           in_range_o
);
  import nnrs_pkg::*;

  nnrs_state_e state_q, state_d;

  logic [SIZE_W-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q;
  logic [SIZE_W-1:0] sw, sh, dw, dh;
  logic [POS_W-1:0]  x_q, y_q;
  logic              hit_q;
  logic              in_acc;
  logic              mem_we, mem_re, div_start;
  logic [ADDR_W-1:0] waddr, raddr;
  pixel_t            wdata, rdata;
  logic              busy_x, busy_y;
  logic [QUOT_W-1:0] qx, qy;
  logic [DIVIDEND_W-1:0] dnd_x, dnd_y;
  logic              out_free, out_load;
  logic              out_valid_q, out_valid_d;
  logic [CHAN_W-1:0] red_q, green_q, blue_q;
  logic              range_q;

  assign sw = clamp_size(src_w_q, MAX_WIDTH);
  assign sh = clamp_size(src_h_q, MAX_HEIGHT);
  assign dw = clamp_size(dst_w_q, MAX_WIDTH);
  assign dh = clamp_size(dst_h_q, MAX_HEIGHT);

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= SIZE_RESET;
      src_h_q <= SIZE_RESET;
      dst_w_q <= SIZE_RESET;
      dst_h_q <= SIZE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_SRC_WIDTH:  src_w_q <= cfg_data_i;
        REG_SRC_HEIGHT: src_h_q <= cfg_data_i;
        REG_DST_WIDTH:  dst_w_q <= cfg_data_i;
        REG_DST_HEIGHT: dst_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign mem_we = in_acc && (operation_i == OP_STORE) &&
                  ({1'b0, pos_x_i} < sw) && ({1'b0, pos_y_i} < sh);
  assign waddr  = pix_addr(SIZE_W'(pos_y_i), SIZE_W'(pos_x_i));
  assign wdata  = {red_in_i, green_in_i, blue_in_i};

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q   <= pos_x_i;
      y_q   <= pos_y_i;
      hit_q <= ({1'b0, pos_x_i} < dw) && ({1'b0, pos_y_i} < dh);
    end
  end

  assign dnd_x = DIVIDEND_W'(x_q) * DIVIDEND_W'(sw);
  assign dnd_y = DIVIDEND_W'(y_q) * DIVIDEND_W'(sh);

  nnrs_div u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dnd_x),
    .divisor_i  (dw),
    .busy_o     (busy_x),
    .quot_o     (qx)
  );

  nnrs_div u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dnd_y),
    .divisor_i  (dh),
    .busy_o     (busy_y),
    .quot_o     (qy)
  );

  assign raddr = pix_addr(qy, qx);

  nnrs_frame_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (mem_re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    mem_re    = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (operation_i == OP_READ)) begin
          state_d = ST_START;
        end
      end
      ST_START: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (!busy_x) begin
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        mem_re  = 1'b1;
        state_d = ST_RSP;
      end
      ST_RSP: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      range_q <= hit_q;
      if (hit_q) begin
        {red_q, green_q, blue_q} <= rdata;
      end else begin
        red_q   <= '0;
        green_q <= '0;
        blue_q  <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_out_o   = red_q;
  assign green_out_o = green_q;
  assign blue_out_o  = blue_q;
  assign in_range_o  = range_q;

  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_x == busy_y)
    else $error("column and row dividers out of step");
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_IDLE))
    else $error("frame write while a read is in flight");
  a_read_then_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD) |=> (state_q == ST_RSP))
    else $error("memory read not followed by response state");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || !out_stall_i))
    else $error("output word overwritten while stalled");

endmodule

[dv/tb_nearest_neighbor_rgb_resize_unit.sv]
// Self-checking testbench for the nearest-neighbor RGB resize unit with its own scaling predictor.
`timescale 1ns / 1ps

module tb_nearest_neighbor_rgb_resize_unit;
  import nnrs_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = '1;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned HALF_BATCH    = 95;
  localparam int unsigned MAX_REPORTS   = 200;

  typedef struct packed {
    logic              op;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    pixel_t            rgb;
  } pixel_word_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              in_range;
  } resized_pixel_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [SIZE_W-1:0]    cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 operation_i = OP_STORE;
  logic [POS_W-1:0]     pos_x_i = '0;
  logic [POS_W-1:0]     pos_y_i = '0;
  logic [CHAN_W-1:0]    red_in_i = '0;
  logic [CHAN_W-1:0]    green_in_i = '0;
  logic [CHAN_W-1:0]    blue_in_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [CHAN_W-1:0]    red_out_o;
  logic [CHAN_W-1:0]    green_out_o;
  logic [CHAN_W-1:0]    blue_out_o;
  logic                 in_range_o;

  logic [SIZE_W-1:0] src_w_reg = SIZE_RESET;
  logic [SIZE_W-1:0] src_h_reg = SIZE_RESET;
  logic [SIZE_W-1:0] dst_w_reg = SIZE_RESET;
  logic [SIZE_W-1:0] dst_h_reg = SIZE_RESET;

  pixel_t         frame_model [0:DEPTH-1];
  bit             written_map [0:DEPTH-1];
  pixel_word_t    pixel_words_pending [$];
  resized_pixel_t expected_pixels [$];
  pixel_word_t    drive_word;
  resized_pixel_t want_pixel;

  int unsigned tx_idle_pct = 19;
  int unsigned rx_idle_pct = 75;
  int unsigned error_count = 0;
  bit          hold_go = 1'b0;
  logic        rx_hold = 1'b0;

  nearest_neighbor_rgb_resize_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .red_in_i    (red_in_i),
    .green_in_i  (green_in_i),
    .blue_in_i   (blue_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .red_out_o   (red_out_o),
    .green_out_o (green_out_o),
    .blue_out_o  (blue_out_o),
    .in_range_o  (in_range_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned effective_size(input logic [SIZE_W-1:0] v,
                                                 input int unsigned max_v);
    if (v == '0) begin
      return 1;
    end
    return (32'(v) > max_v) ? max_v : 32'(v);
  endfunction

  function automatic bit in_dest(input int unsigned x, input int unsigned y);
    return x < effective_size(dst_w_reg, MAX_WIDTH) && y < effective_size(dst_h_reg, MAX_HEIGHT);
  endfunction

  function automatic int unsigned source_addr(input int unsigned x, input int unsigned y);
    int unsigned sx;
    int unsigned sy;
    sx = (x * effective_size(src_w_reg, MAX_WIDTH)) / effective_size(dst_w_reg, MAX_WIDTH);
    sy = (y * effective_size(src_h_reg, MAX_HEIGHT)) / effective_size(dst_h_reg, MAX_HEIGHT);
    return sy * MAX_WIDTH + sx;
  endfunction

  function automatic resized_pixel_t resize_lookup(input logic [POS_W-1:0] x,
                                                   input logic [POS_W-1:0] y);
    resized_pixel_t res;
    pixel_t         pix;
    res = '0;
    if (in_dest(32'(x), 32'(y))) begin
      pix = frame_model[source_addr(32'(x), 32'(y))];
      res.red = pix[23:16];
      res.green = pix[15:8];
      res.blue = pix[7:0];
      res.in_range = 1'b1;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
  endtask

  task automatic queue_store(input int unsigned x, input int unsigned y, input pixel_t rgb);
    pixel_word_t w;
    w.op = OP_STORE;
    w.pos_x = POS_W'(x);
    w.pos_y = POS_W'(y);
    w.rgb = rgb;
    if (x < effective_size(src_w_reg, MAX_WIDTH) && y < effective_size(src_h_reg, MAX_HEIGHT)) begin
      written_map[y * MAX_WIDTH + x] = 1'b1;
    end
    pixel_words_pending.push_back(w);
  endtask

  // A read that maps onto a source pixel never written gets that pixel stored first.
  task automatic queue_read(input int unsigned x, input int unsigned y);
    pixel_word_t w;
    int unsigned addr;
    if (in_dest(x, y)) begin
      addr = source_addr(x, y);
      if (!written_map[addr]) begin
        queue_store(addr % MAX_WIDTH, addr / MAX_WIDTH, PIXEL_W'($urandom));
      end
    end
    w.op = OP_READ;
    w.pos_x = POS_W'(x);
    w.pos_y = POS_W'(y);
    w.rgb = PIXEL_W'($urandom);
    pixel_words_pending.push_back(w);
  endtask

  task automatic queue_random_words(input int unsigned count);
    int unsigned sel;
    int unsigned sw;
    int unsigned sh;
    int unsigned dw;
    int unsigned dh;
    sw = effective_size(src_w_reg, MAX_WIDTH);
    sh = effective_size(src_h_reg, MAX_HEIGHT);
    dw = effective_size(dst_w_reg, MAX_WIDTH);
    dh = effective_size(dst_h_reg, MAX_HEIGHT);
    repeat (count) begin
      sel = $urandom_range(99);
      if (sel < 35) begin
        queue_store($urandom_range(sw - 1), $urandom_range(sh - 1), PIXEL_W'($urandom));
      end else if (sel < 45) begin
        queue_store($urandom_range(255), $urandom_range(255), PIXEL_W'($urandom));
      end else if (sel < 88) begin
        queue_read($urandom_range(dw - 1), $urandom_range(dh - 1));
      end else begin
        queue_read($urandom_range(255), $urandom_range(255));
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pixel_words_pending.size() != 0 || in_valid_i || expected_pixels.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_SRC_WIDTH: src_w_reg = val;
      REG_SRC_HEIGHT: src_h_reg = val;
      REG_DST_WIDTH: dst_w_reg = val;
      REG_DST_HEIGHT: dst_h_reg = val;
      default: ;
    endcase
  endtask

  task automatic set_sizes(input logic [SIZE_W-1:0] sw, input logic [SIZE_W-1:0] sh,
                           input logic [SIZE_W-1:0] dw, input logic [SIZE_W-1:0] dh);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(REG_SRC_WIDTH, sw);
    write_reg(REG_SRC_HEIGHT, sh);
    write_reg(REG_DST_WIDTH, dw);
    write_reg(REG_DST_HEIGHT, dh);
    @(negedge clk_i);
  endtask

  function automatic logic [SIZE_W-1:0] random_size();
    int unsigned sel;
    sel = $urandom_range(19);
    if (sel == 0) begin
      return '0;
    end else if (sel == 1) begin
      return SIZE_W'($urandom_range(511, 257));
    end else if (sel < 7) begin
      return SIZE_W'($urandom_range(16, 1));
    end
    return SIZE_W'($urandom_range(256, 1));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        if (drive_word.op == OP_STORE) begin
          if (drive_word.pos_x < effective_size(src_w_reg, MAX_WIDTH) &&
              drive_word.pos_y < effective_size(src_h_reg, MAX_HEIGHT)) begin
            frame_model[drive_word.pos_y * MAX_WIDTH + drive_word.pos_x] = drive_word.rgb;
          end
        end else begin
          expected_pixels.push_back(resize_lookup(drive_word.pos_x, drive_word.pos_y));
        end
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pixel_words_pending.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          drive_word = pixel_words_pending.pop_front();
          in_valid_i <= 1'b1;
          operation_i <= drive_word.op;
          pos_x_i <= drive_word.pos_x;
          pos_y_i <= drive_word.pos_y;
          red_in_i <= drive_word.rgb[23:16];
          green_in_i <= drive_word.rgb[15:8];
          blue_in_i <= drive_word.rgb[7:0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("unexpected result word", 32'({red_out_o, green_out_o, blue_out_o}),
                          0);
        end else begin
          want_pixel = expected_pixels.pop_front();
          if (red_out_o !== want_pixel.red) begin
            report_mismatch("red_out", 32'(red_out_o), 32'(want_pixel.red));
          end
          if (green_out_o !== want_pixel.green) begin
            report_mismatch("green_out", 32'(green_out_o), 32'(want_pixel.green));
          end
          if (blue_out_o !== want_pixel.blue) begin
            report_mismatch("blue_out", 32'(blue_out_o), 32'(want_pixel.blue));
          end
          if (in_range_o !== want_pixel.in_range) begin
            report_mismatch("in_range", 32'(in_range_o), 32'(want_pixel.in_range));
          end
        end
      end
      out_stall_i <= rx_hold || ($urandom_range(99) < rx_idle_pct);
    end
  end

  // The receiver holds off for a long stretch while the sender keeps offering words.
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin
    #10_000_000;
    $display("FAIL nearest_neighbor_rgb_resize_unit");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Corners of the full-size frame map onto themselves.
    queue_store(0, 0, 24'hFFFFFF);
    queue_store(255, 255, 24'h000000);
    queue_store(255, 0, 24'hA5A5A5);
    queue_store(0, 255, 24'h5A5A5A);
    queue_store(1, 0, 24'h123456);
    queue_read(0, 0);
    queue_read(255, 255);
    queue_read(255, 0);
    queue_read(0, 255);
    queue_read(1, 0);

    // Zero and oversized sizes saturate; writes to unknown indexes change nothing.
    set_sizes('0, '1, SIZE_W'(300), SIZE_W'(2));
    write_reg(REG_SPARE_FIRST, SIZE_W'(5));
    write_reg(REG_SPARE_LAST, '1);
    @(negedge clk_i);
    queue_store(1, 0, 24'hFFFFFF);
    queue_read(0, 0);
    queue_read(255, 1);
    queue_read(0, 2);
    queue_read(255, 255);

    // The store outside the one-pixel-wide source above must not have landed.
    set_sizes(SIZE_RESET, SIZE_RESET, SIZE_RESET, SIZE_RESET);
    queue_read(1, 0);
    queue_store(128, 128, 24'h00FF00);
    queue_read(128, 128);

    for (int phase = 0; phase < 3; phase++) begin
      wait_drained();
      tx_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 75 : 0;
      rx_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 19 : 0;
      for (int k = 0; k < 3; k++) begin
        case (phase * 3 + k)
          0: set_sizes(SIZE_RESET, SIZE_RESET, SIZE_RESET, SIZE_RESET);
          1: set_sizes(SIZE_W'(1), SIZE_W'(1), SIZE_RESET, SIZE_RESET);
          2: set_sizes(SIZE_RESET, SIZE_RESET, SIZE_W'(1), SIZE_W'(1));
          3: set_sizes(SIZE_W'(37), SIZE_W'(200), SIZE_W'(111), SIZE_W'(13));
          default: set_sizes(random_size(), random_size(), random_size(), random_size());
        endcase
        if (phase == 2 && k == 0) begin
          hold_go = 1'b1;
        end
        queue_random_words(HALF_BATCH);
        wait_drained();
        queue_random_words(HALF_BATCH);
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS nearest_neighbor_rgb_resize_unit");
    end else begin
      $display("FAIL nearest_neighbor_rgb_resize_unit");
    end
    $finish;
  end

endmodule

[sim.f]
sv/nnrs_pkg.sv
sv/nnrs_div.sv
sv/nnrs_frame_mem.sv
sv/nearest_neighbor_rgb_resize_unit.sv
dv/tb_nearest_neighbor_rgb_resize_unit.sv
